FILE: hdl/rar_pkg.sv
package rar_pkg;

   localparam int NUM_ANCHORS = 3;
   localparam int ID_W = 8;
   localparam int IDX_W = 2;
   localparam logic [15:0] RANGE_MAX = 16'hFFFF;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   // anchor numbers
   localparam logic [ID_W-1:0] ANCHOR_FIRST = 8'd1;
   localparam logic [ID_W-1:0] ANCHOR_SECOND = 8'd2;
   localparam logic [ID_W-1:0] ANCHOR_THIRD = 8'd3;

   // sequencer of the top level
   typedef enum logic [1:0] {
      T_IDLE,
      T_CHECK,
      T_CALC,
      T_HOLD
   } top_state_type;

   // sequencer of the range unit
   typedef enum logic [2:0] {
      U_IDLE,
      U_DIV,
      U_FIX,
      U_EXP,
      U_OUT
   } unit_state_type;

   // 2^(2^-(step+1)) in Q1.30, step 0..15
   function automatic logic [30:0] root_tab(input logic [3:0] step);
      logic [30:0] t;
      case (step)
         4'd0: t = 31'd1518500250;
         4'd1: t = 31'd1276901417;
         4'd2: t = 31'd1170923762;
         4'd3: t = 31'd1121280436;
         4'd4: t = 31'd1097253708;
         4'd5: t = 31'd1085434106;
         4'd6: t = 31'd1079572136;
         4'd7: t = 31'd1076653033;
         4'd8: t = 31'd1075196444;
         4'd9: t = 31'd1074468887;
         4'd10: t = 31'd1074105294;
         4'd11: t = 31'd1073923544;
         4'd12: t = 31'd1073832680;
         4'd13: t = 31'd1073787251;
         4'd14: t = 31'd1073764537;
         4'd15: t = 31'd1073753181;
         default: t = ONE_Q30;
      endcase
      return t;
   endfunction

endpackage

FILE: hdl/rssi_anchor_ranging_top.sv
// channel  | ports                                               | direction
// req      | req_valid/ready, anchor_id, rssi, ref_near, ref_far | in
// rsp      | rsp_valid/ready, dist_first/second/third, ref_error | out
// After a report that leaves the store incomplete, the block stays ready.
// Unless the references are equal, a completing report runs the range unit once per anchor:
// 24 divide steps, one fix step, 16 multiply steps and one output step each. The result
// beat is valid after the check state and the third run, or after the check alone with
// equal references. One divider and Q1.30 multiplier in the range unit serve all anchors.
// Reset is synchronous and clears the sequencer and the anchor presence bits.
// While a result waits on rsp_ready, req_ready stays low.
module rssi_anchor_ranging_top #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_anchor_id,
   input  logic [7:0]  req_rssi,
   input  logic [7:0]  req_ref_near,
   input  logic [7:0]  req_ref_far,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_dist_first,
   output logic [15:0] rsp_dist_second,
   output logic [15:0] rsp_dist_third,
   output logic        rsp_ref_error
);
   import rar_pkg::*;

   top_state_type state_ff, state_in;

   logic [7:0]             rssi_ff [NUM_ANCHORS];
   logic [7:0]             near_ff [NUM_ANCHORS];
   logic [7:0]             far_ff [NUM_ANCHORS];
   logic [NUM_ANCHORS-1:0] present_ff, present_in;
   logic [IDX_W-1:0]       a_ff;
   logic [15:0]            dist_ff [NUM_ANCHORS];
   logic                   err_ff;

   logic                   accept;
   logic                   id_ok;
   logic [IDX_W-1:0]       wr_idx;
   logic [IDX_W-1:0]       sel_idx;
   logic signed [8:0]      den;
   logic signed [8:0]      num;
   logic                   unit_start;
   logic                   unit_done;
   logic [15:0]            unit_dist;
   logic                   last_anchor;

   assign accept = req_valid && req_ready;
   assign id_ok = (req_anchor_id == ANCHOR_FIRST) || (req_anchor_id == ANCHOR_SECOND) ||
                  (req_anchor_id == ANCHOR_THIRD);
   assign wr_idx = IDX_W'(req_anchor_id - 8'd1);
   assign last_anchor = (a_ff == IDX_W'(NUM_ANCHORS - 1));

   // presence update
   always_comb begin
      present_in = present_ff;
      if (accept && id_ok) begin
         if (req_anchor_id == ANCHOR_FIRST) present_in = '0;
         present_in[wr_idx] = 1'b1;
      end
   end

   // anchor 2 is the reference
   always_comb begin
      sel_idx = (state_ff == T_CHECK) ? '0 : a_ff + IDX_W'(1);
      den = $signed({1'b0, far_ff[1]}) - $signed({1'b0, near_ff[1]});
      num = $signed({1'b0, rssi_ff[sel_idx]}) - $signed({1'b0, near_ff[1]});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept && id_ok && (&present_in)) state_in = T_CHECK;
         end
         T_CHECK: state_in = (den == 9'sd0) ? T_HOLD : T_CALC;
         T_CALC: begin
            if (unit_done && last_anchor) state_in = T_HOLD;
         end
         T_HOLD: begin
            if (rsp_ready) state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == T_IDLE);
      rsp_valid = (state_ff == T_HOLD);
      unit_start = ((state_ff == T_CHECK) && (den != 9'sd0)) ||
                   ((state_ff == T_CALC) && unit_done && !last_anchor);
   end

   assign rsp_dist_first = dist_ff[0];
   assign rsp_dist_second = dist_ff[1];
   assign rsp_dist_third = dist_ff[2];
   assign rsp_ref_error = err_ff;

   rar_range_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_range (
      .clock(clock),
      .reset(reset),
      .start(unit_start),
      .num(num),
      .den(den),
      .done(unit_done),
      .range_out(unit_dist)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         present_ff <= '0;
      end else begin
         state_ff <= state_in;
         present_ff <= present_in;
      end
   end

   // store, anchor count and result
   always_ff @(posedge clock) begin
      if (accept && id_ok) begin
         rssi_ff[wr_idx] <= req_rssi;
         near_ff[wr_idx] <= req_ref_near;
         far_ff[wr_idx] <= req_ref_far;
      end
      if (state_ff == T_CHECK) begin
         a_ff <= '0;
         err_ff <= (den == 9'sd0);
         if (den == 9'sd0) begin
            dist_ff[0] <= '0;
            dist_ff[1] <= '0;
            dist_ff[2] <= '0;
         end
      end
      if ((state_ff == T_CALC) && unit_done) begin
         dist_ff[a_ff] <= unit_dist;
         a_ff <= a_ff + IDX_W'(1);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      unit_done |-> (state_ff == T_CALC))
      else $error("range unit finished outside a calculation");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ref_error) |->
      (rsp_dist_first == 16'd0 && rsp_dist_second == 16'd0 && rsp_dist_third == 16'd0))
      else $error("reference error with nonzero distance");

   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result waits");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_CHECK) |-> (&present_ff))
      else $error("calculation with incomplete store");

endmodule

FILE: hdl/rar_range_unit.sv
module rar_range_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic signed [8:0] num,
   input  logic signed [8:0] den,
   output logic              done,
   output logic [15:0]       range_out
);
   import rar_pkg::*;

   localparam int DIV_STEPS = 24;
   localparam int EXP_STEPS = 16;

   unit_state_type state_ff, state_in;

   logic [7:0]         rem_ff;
   logic [23:0]        quo_ff;
   logic [7:0]         d_ff;
   logic               neg_ff;
   logic [4:0]         cnt_ff;
   logic [15:0]        f_ff;
   logic signed [9:0]  k_ff;
   logic [30:0]        m_ff;

   logic signed [8:0]  num_fix;
   logic [7:0]         num_mag;
   logic [7:0]         den_mag;
   logic [8:0]         div_tmp;
   logic               div_ge;
   logic [8:0]         div_rem;
   logic signed [25:0] quo_fix;
   logic [61:0]        prod;
   logic signed [11:0] kf;
   logic signed [11:0] shamt;
   logic [32:0]        round_sum;
   logic [32:0]        shifted;

   // sign fix so that the divisor is positive
   always_comb begin
      num_fix = (den < 0) ? -num : num;
      num_mag = num_fix[8] ? 8'(-num_fix) : num_fix[7:0];
      den_mag = den[8] ? 8'(-den) : den[7:0];
   end

   // one restoring division step
   always_comb begin
      div_tmp = {rem_ff, quo_ff[23]};
      div_ge = (div_tmp >= {1'b0, d_ff});
      div_rem = div_ge ? (div_tmp - {1'b0, d_ff}) : div_tmp;
   end

   // floor for negative quotients
   always_comb begin
      if (neg_ff) begin
         quo_fix = -($signed({2'b00, quo_ff}) + $signed({25'd0, rem_ff != 8'd0}));
      end else begin
         quo_fix = $signed({2'b00, quo_ff});
      end
   end

   assign prod = m_ff * root_tab(cnt_ff[3:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE: begin
            if (start) state_in = U_DIV;
         end
         U_DIV: begin
            if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = U_FIX;
         end
         U_FIX: state_in = U_EXP;
         U_EXP: begin
            if (cnt_ff == 5'(EXP_STEPS - 1)) state_in = U_OUT;
         end
         U_OUT: begin
            state_in = start ? U_DIV : U_IDLE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (state_ff == U_OUT);
   end

   // scale, round and saturate
   always_comb begin
      kf = 12'(k_ff) + 12'(FRAC_BITS);
      shamt = 12'sd30 - kf;
      round_sum = {2'b00, m_ff} + (33'd1 << (shamt[5:0] - 6'd1));
      shifted = round_sum >> shamt[5:0];
      if (kf >= 12'sd16) begin
         range_out = RANGE_MAX;
      end else if (shamt > 12'sd32) begin
         range_out = '0;
      end else if (shifted > 33'(RANGE_MAX)) begin
         range_out = RANGE_MAX;
      end else begin
         range_out = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         U_IDLE, U_OUT: begin
            if (start) begin
               rem_ff <= '0;
               quo_ff <= {num_mag, 16'h0000};
               d_ff <= den_mag;
               neg_ff <= num_fix[8];
               cnt_ff <= '0;
            end
         end
         U_DIV: begin
            rem_ff <= div_rem[7:0];
            quo_ff <= {quo_ff[22:0], div_ge};
            cnt_ff <= (cnt_ff == 5'(DIV_STEPS - 1)) ? 5'd0 : cnt_ff + 5'd1;
         end
         U_FIX: begin
            k_ff <= quo_fix[25:16];
            f_ff <= quo_fix[15:0];
            m_ff <= ONE_Q30;
            cnt_ff <= '0;
         end
         U_EXP: begin
            if (f_ff[15]) m_ff <= prod[60:30];
            f_ff <= {f_ff[14:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_EXP) |-> (m_ff[30] || m_ff[29]))
      else $error("mantissa left its range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_DIV) |-> (rem_ff < d_ff))
      else $error("remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_FIX) |-> $past(state_ff) == U_DIV)
      else $error("fix step without division");

endmodule

FILE: dv/tb_rssi_anchor_ranging_top.sv
`timescale 1ns / 1ps

module tb_rssi_anchor_ranging_top;
   import rar_pkg::*;

   localparam int FRAC = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [15:0] d1;
      logic [15:0] d2;
      logic [15:0] d3;
      logic        err;
   } range_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_anchor_id;
   logic [7:0]  req_rssi;
   logic [7:0]  req_ref_near;
   logic [7:0]  req_ref_far;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_dist_first;
   logic [15:0] rsp_dist_second;
   logic [15:0] rsp_dist_third;
   logic        rsp_ref_error;

   // shadow of the anchor store
   logic [7:0] sh_rssi [NUM_ANCHORS];
   logic [7:0] sh_near [NUM_ANCHORS];
   logic [7:0] sh_far [NUM_ANCHORS];
   logic       sh_present [NUM_ANCHORS];

   range_beat_type pending_ranges[$];
   int  errors;
   int  cycles;
   bit  sink_idle_on;
   bit  src_idle_on;
   bit  hold_off;

   rssi_anchor_ranging_top #(.FRAC_BITS(FRAC)) uut (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Q30 roots of two, 2^(2^-i)
   function automatic logic [63:0] root_q30(input int i);
      case (i)
         1: return 64'd1518500250;
         2: return 64'd1276901417;
         3: return 64'd1170923762;
         4: return 64'd1121280436;
         5: return 64'd1097253708;
         6: return 64'd1085434106;
         7: return 64'd1079572136;
         8: return 64'd1076653033;
         9: return 64'd1075196444;
         10: return 64'd1074468887;
         11: return 64'd1074105294;
         12: return 64'd1073923544;
         13: return 64'd1073832680;
         14: return 64'd1073787251;
         15: return 64'd1073764537;
         default: return 64'd1073753181;
      endcase
   endfunction

   function automatic int fdiv(input int a, input int b);
      if (a >= 0) return a / b;
      return -((-a + b - 1) / b);
   endfunction

   // distance = 2^(num/den) in Q8.8, saturated
   function automatic logic [15:0] path_loss_range(input int num, input int den);
      int q, k, f, s;
      logic [63:0] m, v;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      q = fdiv(num * 65536, den);
      k = fdiv(q, 65536);
      f = q - k * 65536;
      m = 64'd1 << 30;
      for (int i = 1; i <= 16; i++) begin
         if ((f >> (16 - i)) & 1) m = (m * root_q30(i)) >> 30;
      end
      if (k + FRAC >= 16) return 16'hFFFF;
      s = 30 - k - FRAC;
      if (s > 32) return 16'd0;
      v = (m + (64'd1 << (s - 1))) >> s;
      return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   // update store; queue a range beat when all anchors present
   task automatic predict_report(input logic [7:0] id, input logic [7:0] rs,
                                 input logic [7:0] nr, input logic [7:0] fr);
      int idx, den;
      range_beat_type exp_b;
      if (id == 0 || id > NUM_ANCHORS) return;
      if (id == ANCHOR_FIRST) foreach (sh_present[i]) sh_present[i] = 1'b0;
      idx = id - 1;
      sh_rssi[idx] = rs;
      sh_near[idx] = nr;
      sh_far[idx] = fr;
      sh_present[idx] = 1'b1;
      foreach (sh_present[i]) if (!sh_present[i]) return;
      den = int'(sh_far[1]) - int'(sh_near[1]);
      if (den == 0) begin
         exp_b = '{16'd0, 16'd0, 16'd0, 1'b1};
      end else begin
         exp_b.d1 = path_loss_range(int'(sh_rssi[0]) - int'(sh_near[1]), den);
         exp_b.d2 = path_loss_range(int'(sh_rssi[1]) - int'(sh_near[1]), den);
         exp_b.d3 = path_loss_range(int'(sh_rssi[2]) - int'(sh_near[1]), den);
         exp_b.err = 1'b0;
      end
      pending_ranges = {pending_ranges, exp_b};
   endtask

   // send one report beat; valid drops only while idling
   task automatic send_report(input logic [7:0] id, input logic [7:0] rs,
                              input logic [7:0] nr, input logic [7:0] fr);
      while (src_idle_on && ($urandom_range(99) < 35)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_anchor_id <= id;
      req_rssi <= rs;
      req_ref_near <= nr;
      req_ref_far <= fr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_report(id, rs, nr, fr);
   endtask

   task automatic send_round(input logic [7:0] nr, input logic [7:0] fr);
      send_report(ANCHOR_FIRST, 8'($urandom), 8'($urandom), 8'($urandom));
      send_report(ANCHOR_SECOND, 8'($urandom), nr, fr);
      send_report(ANCHOR_THIRD, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
   endtask

   // field extremes, strange anchors, equal refs, saturation
   task automatic test_directed;
      send_report(8'd0, 8'hFF, 8'hFF, 8'hFF);
      send_report(8'd255, 8'h00, 8'h00, 8'h00);
      send_report(ANCHOR_SECOND, 8'd50, 8'd40, 8'd46);
      send_report(ANCHOR_THIRD, 8'd70, 8'd0, 8'd0);
      send_report(ANCHOR_FIRST, 8'd40, 8'd0, 8'd0);
      send_report(ANCHOR_SECOND, 8'd50, 8'd40, 8'd46);
      send_report(ANCHOR_THIRD, 8'd70, 8'd0, 8'd0);
      send_report(ANCHOR_THIRD, 8'd255, 8'hFF, 8'hFF);
      send_report(8'd4, 8'd1, 8'd2, 8'd3);
      send_report(ANCHOR_SECOND, 8'd9, 8'd77, 8'd77);
      send_report(ANCHOR_FIRST, 8'd255, 8'd255, 8'd0);
      send_report(ANCHOR_SECOND, 8'd0, 8'd0, 8'd255);
      send_report(ANCHOR_THIRD, 8'd255, 8'd0, 8'd0);
      send_report(ANCHOR_FIRST, 8'd0, 8'd0, 8'd0);
      send_report(ANCHOR_SECOND, 8'd255, 8'd255, 8'd0);
      send_report(ANCHOR_THIRD, 8'd0, 8'd0, 8'd0);
      send_report(ANCHOR_FIRST, 8'd200, 8'd0, 8'd0);
      send_report(ANCHOR_SECOND, 8'd100, 8'd100, 8'd1);
      send_report(ANCHOR_THIRD, 8'd101, 8'hAA, 8'h55);
      drain();
   endtask

   // mostly well-formed rounds, plus noise and broken rounds
   task automatic test_random(input int n);
      int sent;
      logic [7:0] nr;
      sent = 0;
      while (sent < n) begin
         nr = 8'($urandom);
         if ($urandom_range(9) < 7) begin
            case ($urandom_range(3))
               0: send_round(nr, nr);
               1: send_round(nr, nr + 8'($urandom_range(1, 8)));
               2: send_round(nr, nr - 8'($urandom_range(1, 8)));
               default: send_round(nr, 8'($urandom));
            endcase
            sent += 3;
         end else begin
            send_report(8'($urandom_range(0, 5)), 8'($urandom), 8'($urandom),
                        8'($urandom));
            if ($urandom_range(3) == 0)
               send_report(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            sent += 1;
         end
      end
      drain();
   endtask

   // receiver holds off long enough for the input to stall
   task automatic test_backpressure;
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            repeat (4) send_round(8'($urandom), 8'($urandom));
         end
      join
      drain();
   endtask

   // result sink: random stalls, compare in order
   always @(posedge clock) begin
      range_beat_type got, exp_b;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_dist_first, rsp_dist_second, rsp_dist_third, rsp_ref_error};
            if (pending_ranges.size() == 0) begin
               $display("%0t: unexpected range beat %h", $time, got);
               errors++;
            end else begin
               exp_b = pending_ranges.pop_front();
               if (got.d1 !== exp_b.d1)
                  $display("%0t: dist_first exp %h got %h", $time, exp_b.d1, got.d1);
               if (got.d2 !== exp_b.d2)
                  $display("%0t: dist_second exp %h got %h", $time, exp_b.d2, got.d2);
               if (got.d3 !== exp_b.d3)
                  $display("%0t: dist_third exp %h got %h", $time, exp_b.d3, got.d3);
               if (got.err !== exp_b.err)
                  $display("%0t: ref_error exp %b got %b", $time, exp_b.err, got.err);
               if (got !== exp_b) errors++;
            end
         end
         rsp_ready <= !hold_off && !(sink_idle_on && ($urandom_range(99) < 35));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      hold_off = 1'b0;
      sink_idle_on = 1'b1;
      src_idle_on = 1'b1;
      foreach (sh_present[i]) sh_present[i] = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_anchor_id <= 8'd0;
      req_rssi <= 8'd0;
      req_ref_near <= 8'd0;
      req_ref_far <= 8'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      // stretch with no idling on either side
      sink_idle_on = 1'b0;
      src_idle_on = 1'b0;
      test_random(100);
      sink_idle_on = 1'b1;
      src_idle_on = 1'b1;
      test_backpressure();
      test_random(100);
      repeat (300) @(posedge clock);
      if (errors == 0 && pending_ranges.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
